>>> hw/rtl/tspf_pkg.sv
package tspf_pkg;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 6;
    localparam int SUM_W   = 33;
    localparam int MAX_PAIRS = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_item;
    } in_word_t;

    typedef struct packed {
        logic                      is_pair;
        logic [INDEX_W-1:0]        low_index;
        logic [INDEX_W-1:0]        high_index;
        logic signed [VALUE_W-1:0] low_value;
        logic signed [VALUE_W-1:0] high_value;
        logic [COUNT_W-1:0]        pair_total;
        logic                      overflowed;
        logic                      final_result;
    } out_word_t;

    // One stored element travelling through the chain
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } entry_t;

    // Control from the sequencer to every cell of one chain
    typedef struct packed {
        logic insert;
        logic shift_down;
        logic clear;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_SUMMARY
    } state_t;

endpackage

>>> hw/rtl/two_sum_pair_finder.sv
// Two-sum pair finder.
// Write target_sum on the cfg channel (cfg_valid/cfg_ready, data in cfg_data);
// cfg_ready follows !busy. Feed values with start; an item is taken when start is
// high and busy is low. Each value enters two chains of MAX_ITEMS cells at once:
// one ascending (low end in its cell 0), one in the reverse order (high end in
// its cell 0). busy stays low while loading, so items may come every cycle.
// The item with last_item set starts the scan: busy rises, and the two cell-0
// words are compared once per cycle; a pair pops both chains, a miss pops one.
// The scan compares until fewer than two words remain or MAX_PAIRS pairs are found;
// the scan state then sees the end, and ST_SUMMARY emits the summary word.
// Each result is shown for one cycle with result_valid: a pair word in the cycle
// after its compare, the summary word in the first cycle with busy low again.
// The receiver cannot stall. Pair words carry indices and values, the summary
// carries the pair count, the overflow flag and final_result. Items beyond
// MAX_ITEMS are dropped and flagged. Reset empties the chains, clears counters
// and sets target_sum to 0; target_sum survives the end of a run.
module two_sum_pair_finder
    import tspf_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  in_word,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic signed [VALUE_W-1:0] cfg_data,
    output logic      result_valid,
    output out_word_t result
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    entry_t     lo_entries [MAX_ITEMS];
    logic       lo_valids  [MAX_ITEMS];
    logic       lo_after   [MAX_ITEMS];
    entry_t     hi_entries [MAX_ITEMS];
    logic       hi_valids  [MAX_ITEMS];
    logic       hi_after   [MAX_ITEMS];
    cell_ctrl_t lo_ctrl;
    cell_ctrl_t hi_ctrl;
    entry_t     new_entry;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0] pairs_reg, pairs_next;
    logic               drop_reg, drop_next;
    logic signed [VALUE_W-1:0] target_reg;
    out_word_t          result_reg, result_next;
    logic               rvalid_reg, rvalid_next;

    logic accept;
    logic signed [SUM_W-1:0] sum;
    logic                    ends_ok;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_LOAD);
    assign cfg_ready = !busy;
    assign new_entry.value = in_word.value;
    assign new_entry.index = INDEX_W'(count_reg);

    // Build the two chains
    genvar g;
    generate
        for (g = 0; g < MAX_ITEMS; g++)
        begin : g_cell
            tspf_cell #(.DESCEND(1'b0)) u_lo_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (lo_ctrl),
                .new_entry   (new_entry),
                .left_entry  (lo_entries[(g == 0) ? 0 : g-1]),
                .left_valid  (g == 0 ? 1'b1 : lo_valids[(g == 0) ? 0 : g-1]),
                .left_greater(g == 0 ? 1'b0 : lo_after[(g == 0) ? 0 : g-1]),
                .right_entry (lo_entries[(g == MAX_ITEMS-1) ? g : g+1]),
                .right_valid (g == MAX_ITEMS-1 ? 1'b0
                                               : lo_valids[(g == MAX_ITEMS-1) ? g : g+1]),
                .entry       (lo_entries[g]),
                .valid       (lo_valids[g]),
                .greater     (lo_after[g])
            );

            tspf_cell #(.DESCEND(1'b1)) u_hi_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (hi_ctrl),
                .new_entry   (new_entry),
                .left_entry  (hi_entries[(g == 0) ? 0 : g-1]),
                .left_valid  (g == 0 ? 1'b1 : hi_valids[(g == 0) ? 0 : g-1]),
                .left_greater(g == 0 ? 1'b0 : hi_after[(g == 0) ? 0 : g-1]),
                .right_entry (hi_entries[(g == MAX_ITEMS-1) ? g : g+1]),
                .right_valid (g == MAX_ITEMS-1 ? 1'b0
                                               : hi_valids[(g == MAX_ITEMS-1) ? g : g+1]),
                .entry       (hi_entries[g]),
                .valid       (hi_valids[g]),
                .greater     (hi_after[g])
            );
        end
    endgenerate

    // Compare the two ends: low end in cell 0 of the ascending chain, high end in
    // cell 0 of the reversed chain; count_reg holds the words still stored, both ends included
    assign sum = SUM_W'(lo_entries[0].value) + SUM_W'(hi_entries[0].value);
    assign ends_ok = (count_reg > CNT_W'(1)) && (pairs_reg < COUNT_W'(MAX_PAIRS));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pairs_next  = pairs_reg;
        drop_next   = drop_reg;
        lo_ctrl     = '0;
        hi_ctrl     = '0;
        rvalid_next = 1'b0;
        result_next = result_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (count_reg < CNT_W'(MAX_ITEMS))
                    begin
                        lo_ctrl.insert = 1'b1;
                        hi_ctrl.insert = 1'b1;
                        count_next     = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (in_word.last_item)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!ends_ok)
                begin
                    state_next = ST_SUMMARY;
                end
                else if (sum == SUM_W'(target_reg))
                begin
                    // Emit pair, pop both ends
                    rvalid_next = 1'b1;
                    result_next.is_pair      = 1'b1;
                    result_next.low_index    = lo_entries[0].index;
                    result_next.high_index   = hi_entries[0].index;
                    result_next.low_value    = lo_entries[0].value;
                    result_next.high_value   = hi_entries[0].value;
                    result_next.pair_total   = pairs_reg + COUNT_W'(1);
                    result_next.overflowed   = drop_reg;
                    result_next.final_result = 1'b0;
                    pairs_next = pairs_reg + COUNT_W'(1);
                    lo_ctrl.shift_down = 1'b1;
                    hi_ctrl.shift_down = 1'b1;
                    count_next = count_reg - CNT_W'(2);
                end
                else if (sum < SUM_W'(target_reg))
                begin
                    lo_ctrl.shift_down = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    hi_ctrl.shift_down = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_SUMMARY:
            begin
                rvalid_next = 1'b1;
                result_next = '0;
                result_next.pair_total   = pairs_reg;
                result_next.overflowed   = drop_reg;
                result_next.final_result = 1'b1;
                lo_ctrl.clear = 1'b1;
                hi_ctrl.clear = 1'b1;
                count_next  = '0;
                pairs_next  = '0;
                drop_next   = 1'b0;
                state_next  = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            pairs_reg  <= '0;
            drop_reg   <= 1'b0;
            target_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pairs_reg  <= pairs_next;
            drop_reg   <= drop_next;
            rvalid_reg <= rvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                target_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = rvalid_reg;
    assign result       = result_reg;

endmodule

>>> hw/rtl/tspf_cell.sv
// One cell of a sorted chain. On insert, a cell takes the left neighbor's word if
// that one ranks after the new word, or the new word if it is the first cell that
// ranks after it (or the first empty cell). During the scan a shift moves every
// word one cell toward cell 0, which drops the word in cell 0.
// DESCEND = 0 keeps the chain ascending with ties in arrival order; DESCEND = 1
// keeps it in the exact reverse of that order.
module tspf_cell
    import tspf_pkg::*;
#(
    parameter bit DESCEND = 1'b0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_entry,
    input  entry_t     left_entry,
    input  logic       left_valid,
    input  logic       left_greater,
    input  entry_t     right_entry,
    input  logic       right_valid,
    output entry_t     entry,
    output logic       valid,
    output logic       greater
);

    entry_t entry_reg, entry_next;
    logic   valid_reg, valid_next;
    logic   after_new;

    // Rank after the incoming word
    assign after_new = DESCEND ? (entry_reg.value <= new_entry.value)
                               : (entry_reg.value > new_entry.value);
    assign greater   = valid_reg && after_new;

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.insert)
        begin
            if (left_greater)
            begin
                entry_next = left_entry;
                valid_next = left_valid;
            end
            else if ((greater || !valid_reg) && left_valid)
            begin
                entry_next = new_entry;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.shift_down)
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    // Hold the valid bit under reset, payload free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

>>> test/tb_top.sv
module tb_top;
    import tspf_pkg::*;

    localparam int CAP = 64;
    localparam int CYCLE_LIMIT = 400000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_word_t  in_word;
    logic      cfg_valid;
    logic      cfg_ready;
    logic signed [VALUE_W-1:0] cfg_data;
    logic      result_valid;
    out_word_t result;

    two_sum_pair_finder #(.MAX_ITEMS(CAP)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .result_valid(result_valid), .result(result)
    );

    // Predictor state: sorted set with arrival indices
    logic signed [63:0] set_vals [CAP];
    logic [INDEX_W-1:0] set_idx [CAP];
    int                 set_count;
    bit                 set_dropped;
    logic signed [63:0] goal_sum;

    out_word_t pending_words [$];
    int        fail_count;
    int        words_seen;
    int        sets_done;
    int        cycle_count;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Guard the run length
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Compare every result word with the oldest prediction
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && result_valid)
        begin
            words_seen++;
            if (pending_words.size() == 0)
            begin
                $error("unexpected result word %p", result);
                fail_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (result.is_pair !== want.is_pair)
                begin
                    $error("is_pair exp %0d got %0d", want.is_pair, result.is_pair);
                    fail_count++;
                end
                if (result.low_index !== want.low_index)
                begin
                    $error("low_index exp %0d got %0d", want.low_index, result.low_index);
                    fail_count++;
                end
                if (result.high_index !== want.high_index)
                begin
                    $error("high_index exp %0d got %0d", want.high_index, result.high_index);
                    fail_count++;
                end
                if (result.low_value !== want.low_value)
                begin
                    $error("low_value exp %0d got %0d", want.low_value, result.low_value);
                    fail_count++;
                end
                if (result.high_value !== want.high_value)
                begin
                    $error("high_value exp %0d got %0d", want.high_value, result.high_value);
                    fail_count++;
                end
                if (result.pair_total !== want.pair_total)
                begin
                    $error("pair_total exp %0d got %0d", want.pair_total, result.pair_total);
                    fail_count++;
                end
                if (result.overflowed !== want.overflowed)
                begin
                    $error("overflowed exp %0d got %0d", want.overflowed, result.overflowed);
                    fail_count++;
                end
                if (result.final_result !== want.final_result)
                begin
                    $error("final_result exp %0d got %0d", want.final_result,
                           result.final_result);
                    fail_count++;
                end
            end
        end
    end

    // Insert one value into the sorted set, or drop it, and scan on last
    task automatic predict_pairs(input in_word_t w);
        int pos;
        int lo;
        int hi;
        int found;
        logic signed [63:0] lv;
        logic signed [63:0] hv;
        out_word_t o;
        if (set_count < CAP)
        begin
            pos = set_count;
            while (pos > 0 && set_vals[pos-1] > 64'(w.value))
            begin
                set_vals[pos] = set_vals[pos-1];
                set_idx[pos] = set_idx[pos-1];
                pos--;
            end
            set_vals[pos] = 64'(w.value);
            set_idx[pos] = INDEX_W'(set_count);
            set_count++;
        end
        else
            set_dropped = 1'b1;
        if (!w.last_item)
            return;
        lo = 0;
        hi = (set_count > 0) ? set_count - 1 : 0;
        found = 0;
        while (lo < hi && found < MAX_PAIRS)
        begin
            lv = set_vals[lo];
            hv = set_vals[hi];
            if (lv + hv == goal_sum)
            begin
                found++;
                o = '0;
                o.is_pair = 1'b1;
                o.low_index = set_idx[lo];
                o.high_index = set_idx[hi];
                o.low_value = lv[31:0];
                o.high_value = hv[31:0];
                o.pair_total = COUNT_W'(found);
                o.overflowed = set_dropped;
                pending_words.push_back(o);
                lo++;
                hi--;
            end
            else if (lv + hv < goal_sum)
                lo++;
            else
                hi--;
        end
        o = '0;
        o.pair_total = COUNT_W'(found);
        o.overflowed = set_dropped;
        o.final_result = 1'b1;
        pending_words.push_back(o);
        set_count = 0;
        set_dropped = 1'b0;
        sets_done++;
    endtask

    // Send one word after a random gap when gaps is set; start stays high into a zero-gap word
    task automatic send_word(input logic signed [31:0] v, input bit last, input bit gaps);
        int gap;
        in_word_t w;
        gap = gaps ? $urandom_range(15, 0) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        w.value = v;
        w.last_item = last;
        start <= 1'b1;
        in_word <= w;
        // busy is stable at the falling edge; low there means the next edge takes it
        @(negedge clk);
        while (busy) @(negedge clk);
        @(posedge clk);
        predict_pairs(w);
    endtask

    // Wait until every predicted word has arrived, then let the block settle
    task automatic drain_results();
        start <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (CAP + 8) @(posedge clk);
    endtask

    task automatic write_target(input logic signed [31:0] t);
        cfg_valid <= 1'b1;
        cfg_data <= t;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        goal_sum = 64'(t);
    endtask

    // Draw a value near a pairing with the target or fully random
    function automatic logic signed [31:0] pick_value(input logic signed [31:0] t);
        case ($urandom_range(3, 0))
            0: return $urandom;
            1: return $signed($urandom_range(20, 0)) - 10;
            default: return t - ($signed($urandom_range(20, 0)) - 10);
        endcase
    endfunction

    task automatic test_extremes();
        write_target(32'sh7fffffff);
        send_word(32'sh7fffffff, 1'b0, 1'b0);
        send_word(32'sh0, 1'b0, 1'b0);
        send_word(32'sh80000000, 1'b0, 1'b1);
        send_word(32'shffffffff, 1'b1, 1'b0);
        drain_results();
        write_target(32'sh80000000);
        send_word(32'sh80000000, 1'b0, 1'b0);
        send_word(32'sh0, 1'b0, 1'b0);
        send_word(32'sh7fffffff, 1'b1, 1'b0);
        drain_results();
        // Single item and ties
        write_target(0);
        send_word(5, 1'b1, 1'b0);
        send_word(0, 1'b0, 1'b0);
        send_word(0, 1'b0, 1'b0);
        send_word(0, 1'b0, 1'b1);
        send_word(0, 1'b1, 1'b0);
        drain_results();
        write_target(32'shffffffff);
        send_word(32'sh55555555, 1'b0, 1'b0);
        send_word(32'shaaaaaaaa, 1'b1, 1'b0);
        drain_results();
    endtask

    // Overfill the set with matching pairs: drop flag and pair limit
    task automatic test_overflow_and_pair_limit();
        int k;
        write_target(0);
        for (k = 0; k < CAP + 3; k++)
            send_word((k % 2) ? -(k / 2 + 1) : (k / 2 + 1), k == CAP + 2, 1'b0);
        drain_results();
    endtask

    task automatic test_random_sets();
        int sent;
        int len;
        int k;
        logic signed [31:0] t;
        sent = 0;
        while (sent < 185)
        begin
            t = ($urandom_range(3, 0) == 0) ? $urandom : $signed($urandom_range(40, 0)) - 20;
            write_target(t);
            len = ($urandom_range(9, 0) == 0) ? $urandom_range(CAP + 4, 1)
                                               : $urandom_range(12, 1);
            for (k = 0; k < len; k++)
                send_word(pick_value(t), k == len - 1, $urandom_range(2, 0) != 0);
            sent += len;
            drain_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        in_word = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        cycle_count = 0;
        fail_count = 0;
        words_seen = 0;
        sets_done = 0;
        set_count = 0;
        set_dropped = 1'b0;
        goal_sum = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_overflow_and_pair_limit();
        test_random_sets();
        drain_results();
        $display("Covered %0d sets and %0d result words, with extremes, ties,",
                 sets_done, words_seen);
        $display("overfilled sets, the pair limit and random targets.");
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
